@@ sv/kct_pkg.sv @@
package kct_pkg;

	// default sizes
	localparam int ENTRIES_DEF    = 64;
	localparam int COORD_BITS_DEF = 8;
	localparam int COST_BITS_DEF  = 16;

	// action codes
	localparam logic [1:0] ACT_LOOKUP = 2'd0;
	localparam logic [1:0] ACT_STORE  = 2'd1;
	localparam logic [1:0] ACT_CLEAR  = 2'd2;

	// register byte addresses
	localparam logic [1:0] ADDR_MISSING_COST = 2'd0;

	// reset value of the missing cost register, before masking to COST_BITS
	localparam logic [15:0] MISSING_COST_RST = 16'hFFFF;

	// control part of the token that walks the cell row
	typedef struct packed {
		logic       vld;
		logic [1:0] action;
		logic       found;
		logic       placed;
	} tok_ctl_t;

endpackage

@@ sv/kct_cell.sv @@
module kct_cell #(
	parameter int IDX        = 0,
	parameter int ENTRIES    = kct_pkg::ENTRIES_DEF,
	parameter int COORD_BITS = kct_pkg::COORD_BITS_DEF,
	parameter int COST_BITS  = kct_pkg::COST_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [$clog2(ENTRIES+1)-1:0]   count,
	input  kct_pkg::tok_ctl_t              ctl_in,
	input  logic [4*COORD_BITS-1:0]        key_in,
	input  logic [COST_BITS-1:0]           ncost_in,
	input  logic [COST_BITS-1:0]           rcost_in,
	output kct_pkg::tok_ctl_t              ctl_out,
	output logic [4*COORD_BITS-1:0]        key_out,
	output logic [COST_BITS-1:0]           ncost_out,
	output logic [COST_BITS-1:0]           rcost_out
);
	import kct_pkg::*;

	localparam int CNT_W = $clog2(ENTRIES+1);
	localparam int KEY_W = 4*COORD_BITS;

	logic [KEY_W-1:0]     key_q;
	logic [COST_BITS-1:0] cost_q;
	logic                 in_range;
	logic                 at_tail;
	logic                 is_store;
	logic                 hit;
	logic                 append;
	tok_ctl_t             ctl_d;
	logic [COST_BITS-1:0] rcost_d;

	// match against the held entry, or claim this slot as the new tail
	assign in_range = CNT_W'(IDX) < count;
	assign at_tail  = CNT_W'(IDX) == count;
	assign is_store = ctl_in.action == ACT_STORE;
	assign hit      = ctl_in.vld && (ctl_in.action != ACT_CLEAR) && in_range &&
	                  (key_q == key_in);
	assign append   = ctl_in.vld && is_store && !ctl_in.found && at_tail;

	always_comb begin
		ctl_d   = ctl_in;
		rcost_d = rcost_in;
		if (hit) begin
			ctl_d.found = 1'b1;
			rcost_d     = is_store ? ncost_in : cost_q;
		end
		if (append) begin
			ctl_d.placed = 1'b1;
			rcost_d      = ncost_in;
		end
	end

	// update the held entry
	always_ff @(posedge clk) begin
		if ((hit && is_store) || append) begin
			cost_q <= ncost_in;
		end
		if (append) begin
			key_q <= key_in;
		end
	end

	// hand the token to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_out <= '0;
		end else begin
			ctl_out <= ctl_d;
		end
	end

	always_ff @(posedge clk) begin
		key_out   <= key_in;
		ncost_out <= ncost_in;
		rcost_out <= rcost_d;
	end

endmodule

@@ sv/keyed_cost_table.sv @@
// A request passes the head register, the row of ENTRIES cells, the pending
// register and the output register. One request is in flight at a time; the token
// walks the row one cell per cycle; the next request is accepted once the last
// response moves to the output register, where it may wait while the next runs.
// Reset (arst_n low, asynchronous): table empty, missing_cost = 65535 masked to
// COST_BITS, no transfer pending on either channel.
module keyed_cost_table #(
	parameter int ENTRIES    = kct_pkg::ENTRIES_DEF,
	parameter int COORD_BITS = kct_pkg::COORD_BITS_DEF,
	parameter int COST_BITS  = kct_pkg::COST_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// request channel
	input  logic                  req_valid,
	output logic                  req_ready,
	input  logic [1:0]            action,
	input  logic [COORD_BITS-1:0] robot_row,
	input  logic [COORD_BITS-1:0] robot_col,
	input  logic [COORD_BITS-1:0] human_row,
	input  logic [COORD_BITS-1:0] human_col,
	input  logic [COST_BITS-1:0]  new_cost,
	// response channel
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output logic                  found,
	output logic [COST_BITS-1:0]  cost,
	output logic                  full_drop,
	// configuration port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [1:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);
	import kct_pkg::*;

	localparam int CNT_W = $clog2(ENTRIES+1);
	localparam int KEY_W = 4*COORD_BITS;
	localparam logic [COST_BITS-1:0] MC_MASK = COST_BITS'(MISSING_COST_RST);

	logic [COST_BITS-1:0] missing_cost_q;
	logic [CNT_W-1:0]     count_q;
	logic                 busy_q;
	logic                 req_xfer;
	logic                 cfg_wr;

	tok_ctl_t             ctl   [ENTRIES+1];
	logic [KEY_W-1:0]     key   [ENTRIES+1];
	logic [COST_BITS-1:0] ncost [ENTRIES+1];
	logic [COST_BITS-1:0] rcost [ENTRIES+1];

	tok_ctl_t             ex_ctl;
	logic                 pend_q;
	logic                 pend_found_q;
	logic [COST_BITS-1:0] pend_cost_q;
	logic                 pend_drop_q;
	logic                 move;

	// configuration register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_MISSING_COST);
	assign prdata = (paddr == ADDR_MISSING_COST) ? 32'(missing_cost_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			missing_cost_q <= MC_MASK;
		end else if (cfg_wr) begin
			missing_cost_q <= pwdata[COST_BITS-1:0] & MC_MASK;
		end
	end

	// one request in flight at a time
	assign req_ready = !busy_q;
	assign req_xfer  = req_valid && req_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (req_xfer) begin
			busy_q <= 1'b1;
		end else if (move) begin
			busy_q <= 1'b0;
		end
	end

	// load the token at the head of the row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl[0] <= '0;
		end else begin
			ctl[0].vld    <= req_xfer;
			ctl[0].action <= action;
			ctl[0].found  <= 1'b0;
			ctl[0].placed <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_xfer) begin
			key[0]   <= {robot_row, robot_col, human_row, human_col};
			ncost[0] <= new_cost;
			rcost[0] <= missing_cost_q;
		end
	end

	// row of table cells
	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		kct_cell #(
			.IDX        (i),
			.ENTRIES    (ENTRIES),
			.COORD_BITS (COORD_BITS),
			.COST_BITS  (COST_BITS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.count     (count_q),
			.ctl_in    (ctl[i]),
			.key_in    (key[i]),
			.ncost_in  (ncost[i]),
			.rcost_in  (rcost[i]),
			.ctl_out   (ctl[i+1]),
			.key_out   (key[i+1]),
			.ncost_out (ncost[i+1]),
			.rcost_out (rcost[i+1])
		);
	end

	assign ex_ctl = ctl[ENTRIES];

	// retire the token: update fill count, capture the response
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ex_ctl.vld) begin
			if (ex_ctl.action == ACT_CLEAR) begin
				count_q <= '0;
			end else if (ex_ctl.placed) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else if (ex_ctl.vld) begin
			pend_q <= 1'b1;
		end else if (move) begin
			pend_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ex_ctl.vld) begin
			pend_found_q <= ex_ctl.found;
			pend_cost_q  <= rcost[ENTRIES];
			pend_drop_q  <= (ex_ctl.action == ACT_STORE) && !ex_ctl.found && !ex_ctl.placed;
		end
	end

	// output register; holds while the consumer stalls
	assign move = pend_q && (!rsp_valid || rsp_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (move) begin
			rsp_valid <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			found     <= pend_found_q;
			cost      <= pend_cost_q;
			full_drop <= pend_drop_q;
		end
	end

endmodule
